// ===== sv/dle_pkg.sv =====
// shared types, codes and helper functions for the multi-list deque engine
package dle_pkg;

   // sizing
   localparam int NUM_LISTS = 4;
   localparam int DEPTH     = 16;
   localparam int LIDX_W    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
   localparam int SLOT_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int SUM_W     = CNT_W + 1;
   localparam int ADDR_W    = LIDX_W + SLOT_W;
   localparam int REC_DEPTH = NUM_LISTS << SLOT_W;

   typedef logic [LIDX_W-1:0] lidx_type;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [ADDR_W-1:0] addr_type;

   // one stored record
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] n;
   } rec_type;

   // per-list ring pointers
   typedef struct packed {
      slot_type front;
      cnt_type  count;
   } ptr_entry_type;

   // pointer table write port
   typedef struct packed {
      logic          we;
      lidx_type      addr;
      ptr_entry_type data;
   } ptr_wr_type;

   // record store write port
   typedef struct packed {
      logic     we;
      addr_type addr;
      rec_type  data;
   } rec_wr_type;

   typedef enum logic [2:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_PEEK_FRONT = 3'd2,
      ACT_PEEK_BACK  = 3'd3,
      ACT_POP_BACK   = 3'd4,
      ACT_MOVE_BACK  = 3'd5,
      ACT_MOVE_FRONT = 3'd6,
      ACT_CLEAR      = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_LOOK = 2'd1,
      S_FIN  = 2'd2
   } state_type;

   // list index from the request field is in range
   function automatic logic list_ok(input logic [1:0] l);
      return 32'(l) < NUM_LISTS;
   endfunction

   // table index from the request field
   function automatic lidx_type to_lidx(input logic [1:0] l);
      return LIDX_W'(l);
   endfunction

   // ring slot at an offset from a slot, offset at most DEPTH
   function automatic slot_type wrap_slot(input slot_type base, input cnt_type off);
      logic [SUM_W-1:0] s;
      s = SUM_W'(base) + SUM_W'(off);
      if (s >= SUM_W'(DEPTH)) begin
         s = s - SUM_W'(DEPTH);
      end
      return s[SLOT_W-1:0];
   endfunction

   // slot one before a slot, around the ring
   function automatic slot_type dec_slot(input slot_type base);
      return (base == '0) ? SLOT_W'(DEPTH - 1) : base - SLOT_W'(1);
   endfunction

endpackage

// ===== sv/dle_ptr_table.sv =====
// per-list pointer table: two registered read ports, one write port, write forwarding
module dle_ptr_table (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   ren,
   input  dle_pkg::lidx_type      raddr_a,
   input  dle_pkg::lidx_type      raddr_b,
   output dle_pkg::ptr_entry_type rdata_a,
   output dle_pkg::ptr_entry_type rdata_b,
   input  dle_pkg::ptr_wr_type    wr
);

   dle_pkg::ptr_entry_type              mem [dle_pkg::NUM_LISTS];
   logic [dle_pkg::NUM_LISTS-1:0]       valid_ff;
   dle_pkg::ptr_entry_type              rdata_a_ff, rdata_a_in;
   dle_pkg::ptr_entry_type              rdata_b_ff, rdata_b_in;

   // valid bits: a list never written reads as empty
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.we) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   // storage write
   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read with forwarding of a same-cycle write
   always_comb begin
      rdata_a_in = '0;
      if (wr.we && wr.addr == raddr_a) begin
         rdata_a_in = wr.data;
      end else if (int'(raddr_a) < dle_pkg::NUM_LISTS && valid_ff[raddr_a]) begin
         rdata_a_in = mem[raddr_a];
      end
      rdata_b_in = '0;
      if (wr.we && wr.addr == raddr_b) begin
         rdata_b_in = wr.data;
      end else if (int'(raddr_b) < dle_pkg::NUM_LISTS && valid_ff[raddr_b]) begin
         rdata_b_in = mem[raddr_b];
      end
   end

   // registered read data
   always_ff @(posedge clock) begin
      if (ren) begin
         rdata_a_ff <= rdata_a_in;
         rdata_b_ff <= rdata_b_in;
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

// ===== sv/dle_rec_store.sv =====
// record memory: one write port and one registered read port
module dle_rec_store (
   input  logic                clock,
   input  dle_pkg::rec_wr_type wr,
   input  logic                ren,
   input  dle_pkg::addr_type   raddr,
   output dle_pkg::rec_type    rdata
);

   dle_pkg::rec_type mem [dle_pkg::REC_DEPTH];
   dle_pkg::rec_type rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (ren) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/multi_list_deque_engine_unit.sv =====
// top level of the multi-list deque engine: request sequencer and result register
// sequence: a registered pointer-table read, then a lookup step with the record-memory read
//    or write, then a finish step that registers the result once the output is free; a new
//    request can be taken in that finish step, overlapping the move's second write
// reset: clears the sequencer, the result valid flag and the pointer valid bits, so all
//    lists start empty; the record memory is not cleared and needs no clearing pass
module multi_list_deque_engine_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_action,
   input  logic [1:0]         req_list_sel,
   input  logic [1:0]         req_dest_list,
   input  logic signed [31:0] req_x_in,
   input  logic signed [31:0] req_y_in,
   input  logic signed [31:0] req_n_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_x_out,
   output logic signed [31:0] rsp_y_out,
   output logic signed [31:0] rsp_n_out,
   output logic [1:0]         rsp_status
);

   dle_pkg::state_type     state_ff, state_in;
   dle_pkg::action_type    act_ff;
   logic [1:0]             src_ff, dst_ff;
   dle_pkg::rec_type       rec_in_ff;
   dle_pkg::status_type    status_ff, status_in;
   logic                   rd_rec_ff, rd_rec_in;
   logic                   mv_ff, mv_in;
   dle_pkg::slot_type      mv_slot_ff, mv_slot_in;
   dle_pkg::ptr_entry_type mv_ent_ff, mv_ent_in;
   logic                   rsp_valid_ff;
   dle_pkg::rec_type       rsp_rec_ff;
   dle_pkg::status_type    rsp_status_ff;

   logic                   accept, out_free;
   dle_pkg::ptr_entry_type src_ent, dst_ent;
   dle_pkg::ptr_wr_type    look_pw, ptr_wr;
   dle_pkg::rec_wr_type    look_rw, rec_wr;
   logic                   look_re;
   dle_pkg::slot_type      look_rslot;
   dle_pkg::rec_type       rec_rdata;
   logic                   src_ok, dst_ok, src_empty, src_full, dst_full;
   dle_pkg::lidx_type      src_idx, dst_idx;

   // pointer lookup for the request being accepted
   dle_ptr_table u_ptr (
      .clock   (clock),
      .reset   (reset),
      .ren     (accept),
      .raddr_a (dle_pkg::to_lidx(req_list_sel)),
      .raddr_b (dle_pkg::to_lidx(req_dest_list)),
      .rdata_a (src_ent),
      .rdata_b (dst_ent),
      .wr      (ptr_wr)
   );

   dle_rec_store u_rec (
      .clock (clock),
      .wr    (rec_wr),
      .ren   (look_re),
      .raddr ({src_idx, look_rslot}),
      .rdata (rec_rdata)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign accept   = req_valid && req_ready;
   assign src_idx  = dle_pkg::to_lidx(src_ff);
   assign dst_idx  = dle_pkg::to_lidx(dst_ff);

   // list conditions
   assign src_ok    = dle_pkg::list_ok(src_ff);
   assign dst_ok    = dle_pkg::list_ok(dst_ff);
   assign src_empty = !src_ok || src_ent.count == '0;
   assign src_full  = !src_ok || src_ent.count >= dle_pkg::CNT_W'(dle_pkg::DEPTH);
   assign dst_full  = !dst_ok || dst_ent.count >= dle_pkg::CNT_W'(dle_pkg::DEPTH);

   // lookup-cycle decode
   always_comb begin
      look_pw      = '0;
      look_pw.addr = src_idx;
      look_rw      = '0;
      look_rw.data = rec_in_ff;
      look_re      = 1'b0;
      look_rslot   = src_ent.front;
      status_in    = dle_pkg::STAT_OK;
      rd_rec_in    = 1'b0;
      mv_in        = 1'b0;
      mv_slot_in   = dst_ent.front;
      mv_ent_in    = dst_ent;
      case (act_ff)
         dle_pkg::ACT_PUSH_FRONT: begin
            if (src_full) begin
               status_in = dle_pkg::STAT_FULL;
            end else begin
               look_pw.we         = 1'b1;
               look_pw.data.front = dle_pkg::dec_slot(src_ent.front);
               look_pw.data.count = src_ent.count + dle_pkg::CNT_W'(1);
               look_rw.we         = 1'b1;
               look_rw.addr       = {src_idx, dle_pkg::dec_slot(src_ent.front)};
            end
         end
         dle_pkg::ACT_PUSH_BACK: begin
            if (src_full) begin
               status_in = dle_pkg::STAT_FULL;
            end else begin
               look_pw.we         = 1'b1;
               look_pw.data.front = src_ent.front;
               look_pw.data.count = src_ent.count + dle_pkg::CNT_W'(1);
               look_rw.we         = 1'b1;
               look_rw.addr       = {src_idx, dle_pkg::wrap_slot(src_ent.front, src_ent.count)};
            end
         end
         dle_pkg::ACT_PEEK_FRONT, dle_pkg::ACT_PEEK_BACK, dle_pkg::ACT_POP_BACK: begin
            if (src_empty) begin
               status_in = dle_pkg::STAT_EMPTY;
            end else begin
               look_re   = 1'b1;
               rd_rec_in = 1'b1;
               if (act_ff != dle_pkg::ACT_PEEK_FRONT) begin
                  look_rslot = dle_pkg::wrap_slot(src_ent.front,
                                                  src_ent.count - dle_pkg::CNT_W'(1));
               end
               if (act_ff == dle_pkg::ACT_POP_BACK) begin
                  look_pw.we         = 1'b1;
                  look_pw.data.front = src_ent.front;
                  look_pw.data.count = src_ent.count - dle_pkg::CNT_W'(1);
               end
            end
         end
         dle_pkg::ACT_MOVE_BACK, dle_pkg::ACT_MOVE_FRONT: begin
            if (src_empty) begin
               status_in = dle_pkg::STAT_EMPTY;
            end else if (src_ff == dst_ff) begin
               status_in = dle_pkg::STAT_OK;
            end else if (dst_full) begin
               status_in = dle_pkg::STAT_FULL;
            end else begin
               look_re            = 1'b1;
               mv_in              = 1'b1;
               look_pw.we         = 1'b1;
               look_pw.data.count = src_ent.count - dle_pkg::CNT_W'(1);
               mv_ent_in.count    = dst_ent.count + dle_pkg::CNT_W'(1);
               if (act_ff == dle_pkg::ACT_MOVE_BACK) begin
                  look_rslot         = dle_pkg::wrap_slot(src_ent.front,
                                                          src_ent.count - dle_pkg::CNT_W'(1));
                  look_pw.data.front = src_ent.front;
                  mv_slot_in         = dle_pkg::wrap_slot(dst_ent.front, dst_ent.count);
                  mv_ent_in.front    = dst_ent.front;
               end else begin
                  look_rslot         = src_ent.front;
                  look_pw.data.front = dle_pkg::wrap_slot(src_ent.front, dle_pkg::CNT_W'(1));
                  mv_slot_in         = dle_pkg::dec_slot(dst_ent.front);
                  mv_ent_in.front    = dle_pkg::dec_slot(dst_ent.front);
               end
            end
         end
         dle_pkg::ACT_CLEAR: begin
            look_pw.we   = src_ok;
            look_pw.data = '0;
         end
         default: begin
            status_in = dle_pkg::STAT_OK;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dle_pkg::S_IDLE: begin
            if (accept) state_in = dle_pkg::S_LOOK;
         end
         dle_pkg::S_LOOK: begin
            state_in = dle_pkg::S_FIN;
         end
         dle_pkg::S_FIN: begin
            if (out_free) state_in = req_valid ? dle_pkg::S_LOOK : dle_pkg::S_IDLE;
         end
         default: begin
            state_in = dle_pkg::S_IDLE;
         end
      endcase
   end

   // state outputs: handshake and memory write selection
   always_comb begin
      req_ready = 1'b0;
      ptr_wr    = '0;
      rec_wr    = '0;
      case (state_ff)
         dle_pkg::S_IDLE: begin
            req_ready = 1'b1;
         end
         dle_pkg::S_LOOK: begin
            ptr_wr = look_pw;
            rec_wr = look_rw;
         end
         dle_pkg::S_FIN: begin
            req_ready = out_free;
            // second half of a move: destination record and pointers
            ptr_wr.we   = mv_ff;
            ptr_wr.addr = dst_idx;
            ptr_wr.data = mv_ent_ff;
            rec_wr.we   = mv_ff;
            rec_wr.addr = {dst_idx, mv_slot_ff};
            rec_wr.data = rec_rdata;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dle_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         mv_ff        <= 1'b0;
         rd_rec_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == dle_pkg::S_LOOK) begin
            mv_ff     <= mv_in;
            rd_rec_ff <= rd_rec_in;
         end
         if (state_ff == dle_pkg::S_FIN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff      <= dle_pkg::action_type'(req_action);
         src_ff      <= req_list_sel;
         dst_ff      <= req_dest_list;
         rec_in_ff.x <= req_x_in;
         rec_in_ff.y <= req_y_in;
         rec_in_ff.n <= req_n_in;
      end
   end

   // lookup results
   always_ff @(posedge clock) begin
      if (state_ff == dle_pkg::S_LOOK) begin
         status_ff  <= status_in;
         mv_slot_ff <= mv_slot_in;
         mv_ent_ff  <= mv_ent_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (state_ff == dle_pkg::S_FIN && out_free) begin
         rsp_status_ff <= status_ff;
         rsp_rec_ff    <= rd_rec_ff ? rec_rdata : '0;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_x_out  = rsp_rec_ff.x;
   assign rsp_y_out  = rsp_rec_ff.y;
   assign rsp_n_out  = rsp_rec_ff.n;
   assign rsp_status = rsp_status_ff;

`ifndef NO_ASSERTIONS
   // a result appears only at the end of a request
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == dle_pkg::S_FIN)
      else $error("result appeared outside the finish step");

   // no request is taken during the lookup step
   a_no_accept_look: assert property (@(posedge clock) disable iff (reset)
      state_ff == dle_pkg::S_LOOK |-> !req_ready)
      else $error("request taken during lookup");

   // a move's second write never targets its own source list
   a_move_dest: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dle_pkg::S_FIN && mv_ff) |-> src_ff != dst_ff)
      else $error("move writes back into its source list");

   // failed requests carry a zero record
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != dle_pkg::STAT_OK) |-> rsp_rec_ff == '0)
      else $error("failed request returned a record");

   // the finish step always follows a lookup or holds
   a_fin_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == dle_pkg::S_FIN |->
         ($past(state_ff) == dle_pkg::S_LOOK || $past(state_ff) == dle_pkg::S_FIN))
      else $error("finish step entered out of order");
`endif

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for the multi-list deque engine
`timescale 1ns / 1ps

module tb_top;

   // expected outcome of one request
   typedef struct packed {
      dle_pkg::rec_type    rec;
      dle_pkg::status_type status;
   } deque_result_type;

   // request mixes for the random traffic
   typedef enum int {
      MIX_FILL  = 0,
      MIX_DRAIN = 1,
      MIX_EVEN  = 2
   } traffic_mix_type;

   logic               clock;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_ready;
   logic [2:0]         req_action    = dle_pkg::ACT_CLEAR;
   logic [1:0]         req_list_sel  = '0;
   logic [1:0]         req_dest_list = '0;
   logic signed [31:0] req_x_in      = '0;
   logic signed [31:0] req_y_in      = '0;
   logic signed [31:0] req_n_in      = '0;
   logic               rsp_valid;
   logic               rsp_ready     = 1'b0;
   logic signed [31:0] rsp_x_out;
   logic signed [31:0] rsp_y_out;
   logic signed [31:0] rsp_n_out;
   logic [1:0]         rsp_status;

   // shadow copy of the lists
   dle_pkg::rec_type ring_store [dle_pkg::NUM_LISTS][dle_pkg::DEPTH];
   int               front_slot [dle_pkg::NUM_LISTS];
   int               fill       [dle_pkg::NUM_LISTS];

   deque_result_type pending_results [$];

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int error_count   = 0;
   int results_seen  = 0;
   int action_seen [8];
   int status_seen [3];

   multi_list_deque_engine_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_list_sel  (req_list_sel),
      .req_dest_list (req_dest_list),
      .req_x_in      (req_x_in),
      .req_y_in      (req_y_in),
      .req_n_in      (req_n_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_x_out     (rsp_x_out),
      .rsp_y_out     (rsp_y_out),
      .rsp_n_out     (rsp_n_out),
      .rsp_status    (rsp_status)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

   // ring slot of the back record
   function automatic int back_slot(int l);
      return (front_slot[l] + fill[l] - 1) % dle_pkg::DEPTH;
   endfunction

   function automatic void place_front(int l, dle_pkg::rec_type r);
      front_slot[l] = (front_slot[l] + dle_pkg::DEPTH - 1) % dle_pkg::DEPTH;
      fill[l]++;
      ring_store[l][front_slot[l]] = r;
   endfunction

   function automatic void place_back(int l, dle_pkg::rec_type r);
      fill[l]++;
      ring_store[l][back_slot(l)] = r;
   endfunction

   // apply one request to the shadow lists and queue its outcome
   function automatic void predict_deque_op(dle_pkg::action_type act, logic [1:0] src,
                                            logic [1:0] dst, dle_pkg::rec_type rin);
      deque_result_type res;
      dle_pkg::rec_type moved;
      int               s;
      int               d;
      int               a;
      bit               src_live;
      bit               dst_live;
      res.rec    = '0;
      res.status = dle_pkg::STAT_OK;
      s = int'(src);
      d = int'(dst);
      src_live = s < dle_pkg::NUM_LISTS;
      dst_live = d < dle_pkg::NUM_LISTS;
      case (act)
         dle_pkg::ACT_PUSH_FRONT, dle_pkg::ACT_PUSH_BACK: begin
            if (!src_live || fill[s] >= dle_pkg::DEPTH) begin
               res.status = dle_pkg::STAT_FULL;
            end else if (act == dle_pkg::ACT_PUSH_FRONT) begin
               place_front(s, rin);
            end else begin
               place_back(s, rin);
            end
         end
         dle_pkg::ACT_PEEK_FRONT, dle_pkg::ACT_PEEK_BACK, dle_pkg::ACT_POP_BACK: begin
            if (!src_live || fill[s] == 0) begin
               res.status = dle_pkg::STAT_EMPTY;
            end else begin
               a = (act == dle_pkg::ACT_PEEK_FRONT) ? front_slot[s] : back_slot(s);
               res.rec = ring_store[s][a];
               if (act == dle_pkg::ACT_POP_BACK) begin
                  fill[s]--;
               end
            end
         end
         dle_pkg::ACT_MOVE_BACK, dle_pkg::ACT_MOVE_FRONT: begin
            // empty source wins over full destination; same list is a no-op
            if (!src_live || fill[s] == 0) begin
               res.status = dle_pkg::STAT_EMPTY;
            end else if (s == d) begin
               res.status = dle_pkg::STAT_OK;
            end else if (!dst_live || fill[d] >= dle_pkg::DEPTH) begin
               res.status = dle_pkg::STAT_FULL;
            end else begin
               a = (act == dle_pkg::ACT_MOVE_BACK) ? back_slot(s) : front_slot[s];
               moved = ring_store[s][a];
               fill[s]--;
               if (act == dle_pkg::ACT_MOVE_BACK) begin
                  place_back(d, moved);
               end else begin
                  front_slot[s] = (front_slot[s] + 1) % dle_pkg::DEPTH;
                  place_front(d, moved);
               end
            end
         end
         default: begin
            if (src_live) begin
               fill[s]       = 0;
               front_slot[s] = 0;
            end
         end
      endcase
      pending_results.push_back(res);
   endfunction

   // drive one request and wait for it to be taken
   task automatic send_request(dle_pkg::action_type act, logic [1:0] src, logic [1:0] dst,
                               dle_pkg::rec_type rin);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_list_sel  <= src;
      req_dest_list <= dst;
      req_x_in      <= rin.x;
      req_y_in      <= rin.y;
      req_n_in      <= rin.n;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_deque_op(act, src, dst, rin);
      action_seen[int'(act)]++;
   endtask

   // result checker with random back-pressure
   always @(posedge clock) begin
      deque_result_type want;
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            error_count++;
            $error("result with none expected: status %0d", rsp_status);
         end else begin
            want = pending_results.pop_front();
            if (rsp_x_out !== want.rec.x) begin
               error_count++;
               $error("x_out mismatch: expected %0d, got %0d", want.rec.x, rsp_x_out);
            end
            if (rsp_y_out !== want.rec.y) begin
               error_count++;
               $error("y_out mismatch: expected %0d, got %0d", want.rec.y, rsp_y_out);
            end
            if (rsp_n_out !== want.rec.n) begin
               error_count++;
               $error("n_out mismatch: expected %0d, got %0d", want.rec.n, rsp_n_out);
            end
            if (rsp_status !== want.status) begin
               error_count++;
               $error("status mismatch: expected %0d, got %0d", want.status, rsp_status);
            end
            status_seen[int'(want.status)]++;
         end
      end
   end

   // random word with the extremes showing up often
   function automatic logic [31:0] pick_word();
      case ($urandom_range(19))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'hffff_ffff;
         3:       return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   function automatic dle_pkg::rec_type random_rec();
      dle_pkg::rec_type r;
      r.x = pick_word();
      r.y = pick_word();
      r.n = pick_word();
      return r;
   endfunction

   // weighted action choice per traffic mix
   function automatic dle_pkg::action_type pick_action(traffic_mix_type mix);
      dle_pkg::action_type acts [8] = '{dle_pkg::ACT_PUSH_FRONT, dle_pkg::ACT_PUSH_BACK,
                                        dle_pkg::ACT_PEEK_FRONT, dle_pkg::ACT_PEEK_BACK,
                                        dle_pkg::ACT_POP_BACK, dle_pkg::ACT_MOVE_BACK,
                                        dle_pkg::ACT_MOVE_FRONT, dle_pkg::ACT_CLEAR};
      int unsigned cut [8];
      int unsigned r;
      case (mix)
         MIX_FILL:  cut = '{30, 60, 66, 72, 80, 88, 97, 100};
         MIX_DRAIN: cut = '{10, 20, 28, 36, 62, 78, 96, 100};
         default:   cut = '{20, 40, 50, 60, 72, 84, 96, 100};
      endcase
      r = $urandom_range(99);
      for (int i = 0; i < 8; i++) begin
         if (r < cut[i]) begin
            return acts[i];
         end
      end
      return dle_pkg::ACT_CLEAR;
   endfunction

   // push, peek and pop on one list with extreme records
   task automatic test_single_list_ops();
      send_request(dle_pkg::ACT_PUSH_BACK, 2'd0, 2'd3,
                   '{32'sh7fff_ffff, 32'sh8000_0000, 32'shffff_ffff});
      send_request(dle_pkg::ACT_PUSH_FRONT, 2'd0, 2'd2,
                   '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0});
      send_request(dle_pkg::ACT_PEEK_FRONT, 2'd0, 2'd1, random_rec());
      send_request(dle_pkg::ACT_PEEK_BACK, 2'd0, 2'd0, random_rec());
      send_request(dle_pkg::ACT_POP_BACK, 2'd0, 2'd3, random_rec());
      send_request(dle_pkg::ACT_POP_BACK, 2'd0, 2'd3, random_rec());
   endtask

   // full list, empty list and move corner cases
   task automatic test_full_and_empty_cases();
      dle_pkg::rec_type r;
      // fill list 1 from both ends
      for (int i = 0; i < dle_pkg::DEPTH; i++) begin
         r.x = 32'(i);
         r.y = -32'(i);
         r.n = ~32'(i);
         send_request((i % 2 == 1) ? dle_pkg::ACT_PUSH_FRONT : dle_pkg::ACT_PUSH_BACK,
                      2'd1, 2'd0, r);
      end
      send_request(dle_pkg::ACT_PUSH_BACK, 2'd1, 2'd0, random_rec());
      send_request(dle_pkg::ACT_MOVE_FRONT, 2'd1, 2'd1, random_rec());
      // empty source with full destination
      send_request(dle_pkg::ACT_MOVE_BACK, 2'd0, 2'd1, random_rec());
      send_request(dle_pkg::ACT_POP_BACK, 2'd0, 2'd0, random_rec());
      send_request(dle_pkg::ACT_PEEK_FRONT, 2'd3, 2'd0, random_rec());
      send_request(dle_pkg::ACT_PEEK_BACK, 2'd2, 2'd0, random_rec());
      send_request(dle_pkg::ACT_CLEAR, 2'd2, 2'd0, random_rec());
      send_request(dle_pkg::ACT_PUSH_FRONT, 2'd0, 2'd0, random_rec());
      send_request(dle_pkg::ACT_MOVE_BACK, 2'd0, 2'd1, random_rec());
      send_request(dle_pkg::ACT_MOVE_FRONT, 2'd1, 2'd2, random_rec());
      send_request(dle_pkg::ACT_MOVE_BACK, 2'd1, 2'd3, random_rec());
      send_request(dle_pkg::ACT_MOVE_BACK, 2'd2, 2'd2, random_rec());
      send_request(dle_pkg::ACT_PEEK_FRONT, 2'd2, 2'd0, random_rec());
      send_request(dle_pkg::ACT_PEEK_BACK, 2'd3, 2'd0, random_rec());
      send_request(dle_pkg::ACT_CLEAR, 2'd1, 2'd0, random_rec());
      send_request(dle_pkg::ACT_PEEK_FRONT, 2'd1, 2'd0, random_rec());
   endtask

   // mixed traffic focused on one hot list at a time, under four idle patterns
   task automatic test_random_traffic();
      int              src_idle [4] = '{0, 84, 0, 7};
      int              dst_stall [4] = '{0, 0, 84, 7};
      traffic_mix_type mix;
      logic [1:0]      hot;
      logic [1:0]      src;
      mix = MIX_EVEN;
      hot = '0;
      for (int p = 0; p < 4; p++) begin
         req_idle_pct  = src_idle[p];
         rsp_stall_pct = dst_stall[p];
         for (int i = 0; i < 275; i++) begin
            if (i % 40 == 0) begin
               mix = traffic_mix_type'($urandom_range(2));
               hot = 2'($urandom_range(3));
            end
            src = ($urandom_range(9) < 6) ? hot : 2'($urandom_range(3));
            send_request(pick_action(mix), src, 2'($urandom_range(3)), random_rec());
         end
      end
   endtask

   // main sequence
   initial begin
      int guard;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_single_list_ops();
      test_full_and_empty_cases();
      test_random_traffic();
      req_valid     <= 1'b0;
      rsp_stall_pct = 0;
      // drain outstanding results
      guard = 0;
      while (pending_results.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      if (pending_results.size() != 0) begin
         error_count++;
         $error("%0d results never arrived", pending_results.size());
      end
      repeat (10) @(posedge clock);
      $display("covered %0d requests: push %0d/%0d peek %0d/%0d pop %0d move %0d/%0d clear %0d",
               action_seen.sum(), action_seen[0], action_seen[1], action_seen[2],
               action_seen[3], action_seen[4], action_seen[5], action_seen[6],
               action_seen[7]);
      $display("checked %0d results: ok %0d, empty %0d, full %0d",
               results_seen, status_seen[0], status_seen[1], status_seen[2]);
      if (error_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
